### src/deht_pkg.sv
// Shared types and constants of the device encounter hysteresis table.
`default_nettype none
package deht_pkg;
   localparam int TABLE_ENTRIES = 16;
   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] OP_DISCOVER = 2'd0;
   localparam logic [1:0] OP_CONFIRM = 2'd1;
   localparam logic [1:0] OP_SWEEP = 2'd2;

   localparam logic [2:0] CSR_MIN_DWELL = 3'd0;
   localparam logic [2:0] CSR_DISC_TIMEOUT = 3'd1;
   localparam logic [2:0] CSR_SIGHTINGS = 3'd2;
   localparam logic [2:0] CSR_ENC_TIMEOUT = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD = 3'd4;

   localparam logic KIND_DISCOVER = 1'b0;
   localparam logic KIND_REMOVED = 1'b1;

   // entry layout in RAM: encountered, id, count, first, last
   localparam int ENTRY_W = 1 + 32 + 8 + 32 + 32;

   typedef struct packed {
      logic        encountered;
      logic [31:0] id;
      logic [7:0]  count;
      logic [31:0] first_ms;
      logic [31:0] last_ms;
   } entry_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [31:0]        device_id;
      logic signed [7:0]  strength;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] out_device_id;
      logic        handshake;
      logic        newly_discovered;
      logic        table_full;
      logic [31:0] event_time_ms;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

### src/device_encounter_hysteresis_table.sv
// Top level of the device encounter hysteresis table.
`default_nettype none
// Holds up to TABLE_ENTRIES devices. Entry payload lives in one RAM with a
// registered read; valid bits are flip-flops cleared by reset. One request
// at a time: a discover or confirm scans all entries (one RAM read per cycle),
// then rereads the chosen entry (ST_READ), updates it and writes it back
// (ST_UPDATE). A discover then presents its answer from ST_RESP; the next
// request can be accepted once the block is back in ST_IDLE and the answer
// has been taken or is being taken. A confirm gives no answer and goes back
// to ST_IDLE straight from ST_UPDATE.
// A sweep walks the entries in the same way and emits one removed-entry
// report per stale entry; after the walk, ST_FLUSH sends the final held
// report, if any. The last report of a sweep is found by a lookahead: a
// pending removal is held until the next stale entry (or the end of the
// table) is known. The walk stalls while a report is blocked by rsp_ready,
// and a new request is not accepted while an answer waits. Op 3 is dropped
// without a response.
module device_encounter_hysteresis_table (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire deht_pkg::req_type         req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output deht_pkg::rsp_type              rsp_data,
   input  wire logic                      csr_write,
   input  wire logic [2:0]                csr_index,
   input  wire logic [31:0]               csr_wdata
);
   localparam int N = deht_pkg::TABLE_ENTRIES;
   localparam int SW = deht_pkg::SLOT_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_SWEEP  = 3'd4;
   localparam logic [2:0] ST_FLUSH  = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   // configuration
   logic [31:0]       min_dwell_ff, disc_to_ff, enc_to_ff;
   logic [7:0]        sight_ff;
   logic signed [7:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dwell_ff <= '0;
         disc_to_ff <= '0;
         sight_ff <= '0;
         enc_to_ff <= '0;
         thresh_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            deht_pkg::CSR_MIN_DWELL:    min_dwell_ff <= csr_wdata;
            deht_pkg::CSR_DISC_TIMEOUT: disc_to_ff <= csr_wdata;
            deht_pkg::CSR_SIGHTINGS:    sight_ff <= csr_wdata[7:0];
            deht_pkg::CSR_ENC_TIMEOUT:  enc_to_ff <= csr_wdata;
            deht_pkg::CSR_THRESHOLD:    thresh_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic [2:0]          state_ff;
   deht_pkg::req_type   req_ff;
   logic [N-1:0]        valid_ff;
   logic [SW:0]         scan_ff;      // read address issued, with end bit
   logic [SW-1:0]       rd_idx_ff;    // slot whose data arrives this cycle
   logic                rd_live_ff;
   logic                hit_ff;
   logic [SW-1:0]       hit_idx_ff;
   deht_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;
   logic                pend_ff;      // a removal report held for lookahead
   deht_pkg::rsp_type   pend_rsp_ff;

   // RAM
   logic                wr_en;
   logic [SW-1:0]       wr_addr, rd_addr;
   deht_pkg::entry_type wr_entry, rd_entry;

   deht_ram #(.WIDTH(deht_pkg::ENTRY_W), .DEPTH(N)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // lowest free slot
   logic          free_any;
   logic [SW-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   logic rd_match, stale;
   logic [31:0] idle;
   assign rd_match = rd_live_ff && valid_ff[rd_idx_ff] && rd_entry.id == req_ff.device_id;
   assign idle = req_ff.now_ms - rd_entry.last_ms;
   assign stale = rd_live_ff && valid_ff[rd_idx_ff] &&
                  (idle > (rd_entry.encountered ? enc_to_ff : disc_to_ff));

   // discover / confirm update of a hit entry
   deht_pkg::entry_type upd;
   logic hs;
   always_comb begin
      upd = rd_entry;
      upd.last_ms = req_ff.now_ms;
      hs = 1'b0;
      if (req_ff.op == deht_pkg::OP_CONFIRM) begin
         upd = rd_entry;
         upd.encountered = 1'b1;
      end else begin
         if (req_ff.strength > thresh_ff && rd_entry.count != 8'hFF) begin
            upd.count = rd_entry.count + 8'd1;
         end
         if (rd_entry.encountered) begin
            hs = 1'b1;
         end else if (upd.count >= sight_ff &&
                      (req_ff.now_ms - rd_entry.first_ms) >= min_dwell_ff) begin
            upd.encountered = 1'b1;
            hs = 1'b1;
         end
      end
   end

   // a fresh entry; count may already tick and promote on the first sighting
   deht_pkg::entry_type fresh;
   logic fresh_hs;
   always_comb begin
      fresh.encountered = (req_ff.op == deht_pkg::OP_CONFIRM);
      fresh.id = req_ff.device_id;
      fresh.count = (req_ff.op == deht_pkg::OP_DISCOVER && req_ff.strength > thresh_ff)
                    ? 8'd1 : 8'd0;
      fresh.first_ms = req_ff.now_ms;
      fresh.last_ms = req_ff.now_ms;
      fresh_hs = 1'b0;
      if (req_ff.op == deht_pkg::OP_DISCOVER && fresh.count >= sight_ff &&
          min_dwell_ff == 32'd0) begin
         fresh.encountered = 1'b1;
         fresh_hs = 1'b1;
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   // hold the sweep walk while a stale entry finds its report slot blocked
   logic sweep_stall;
   assign sweep_stall = (state_ff == ST_SWEEP) && stale && pend_ff && !out_free;

   // load a new answer into the output register this cycle
   logic rsp_load;
   assign rsp_load = ((state_ff == ST_RESP) && out_free) ||
                     ((state_ff == ST_SWEEP) && stale && pend_ff && out_free) ||
                     ((state_ff == ST_FLUSH) && pend_ff && out_free);

   always_comb begin
      rd_addr = scan_ff[SW-1:0];
      wr_en = 1'b0;
      wr_addr = hit_idx_ff;
      wr_entry = upd;
      if (state_ff == ST_READ) begin
         rd_addr = hit_idx_ff;
      end
      // reissue the read of the held slot so its data is back next cycle
      if (sweep_stall) begin
         rd_addr = rd_idx_ff;
      end
      if (state_ff == ST_UPDATE && hit_ff) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_UPDATE && free_any) begin
         wr_en = 1'b1;
         wr_addr = free_idx;
         wr_entry = fresh;
      end
   end

   deht_pkg::rsp_type rem;
   always_comb begin
      rem.kind = deht_pkg::KIND_REMOVED;
      rem.out_device_id = rd_entry.id;
      rem.handshake = 1'b0;
      rem.newly_discovered = 1'b0;
      rem.table_full = 1'b0;
      rem.event_time_ms = rd_entry.last_ms;
      rem.last = 1'b0;
   end

   // the held report marked as the final one of its sweep
   deht_pkg::rsp_type pend_last;
   always_comb begin
      pend_last = pend_rsp_ff;
      pend_last.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         rd_live_ff <= 1'b0;
         hit_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               rd_live_ff <= 1'b0;
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  hit_ff <= 1'b0;
                  scan_ff <= '0;
                  if (req_data.op == deht_pkg::OP_SWEEP) begin
                     state_ff <= ST_SWEEP;
                  end else if (req_data.op == deht_pkg::OP_DISCOVER ||
                               req_data.op == deht_pkg::OP_CONFIRM) begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               // advance the read address; compare the data of the prior one
               if (rd_match) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= rd_idx_ff;
               end
               rd_idx_ff <= scan_ff[SW-1:0];
               rd_live_ff <= !scan_ff[SW] && (scan_ff < (SW+1)'(N));
               if (scan_ff == (SW+1)'(N)) begin
                  state_ff <= ST_READ;
               end else begin
                  scan_ff <= scan_ff + (SW+1)'(1);
               end
            end
            ST_READ: begin
               rd_live_ff <= 1'b0;
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (!hit_ff && free_any) begin
                  valid_ff[free_idx] <= 1'b1;
               end
               if (req_ff.op == deht_pkg::OP_DISCOVER) begin
                  rsp_ff.kind <= deht_pkg::KIND_DISCOVER;
                  rsp_ff.out_device_id <= req_ff.device_id;
                  rsp_ff.handshake <= hit_ff ? hs : (free_any && fresh_hs);
                  rsp_ff.newly_discovered <= !hit_ff && free_any;
                  rsp_ff.table_full <= !hit_ff && !free_any;
                  rsp_ff.event_time_ms <= (!hit_ff && free_any) ? req_ff.now_ms : 32'd0;
                  rsp_ff.last <= 1'b1;
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RESP: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SWEEP: begin
               if (!sweep_stall) begin
                  if (stale) begin
                     valid_ff[rd_idx_ff] <= 1'b0;
                     pend_ff <= 1'b1;
                     pend_rsp_ff <= rem;
                     if (pend_ff) begin
                        rsp_ff <= pend_rsp_ff;
                     end
                  end
                  rd_idx_ff <= scan_ff[SW-1:0];
                  rd_live_ff <= (scan_ff < (SW+1)'(N));
                  if (scan_ff == (SW+1)'(N)) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     scan_ff <= scan_ff + (SW+1)'(1);
                  end
               end
            end
            ST_FLUSH: begin
               rd_live_ff <= 1'b0;
               if (!pend_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_ff <= pend_last;
                  pend_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE ||
                                 !$past(req_data.op == deht_pkg::OP_DISCOVER))
      else $error("discover accepted without scan");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_ff)
      else $error("removal report left pending");
endmodule
`default_nettype wire

### src/deht_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module deht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### dv/tb_top.sv
// Testbench for the device encounter hysteresis table: directed and random requests checked
// against a built-in predictor of the table.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   localparam int NSLOT = deht_pkg::TABLE_ENTRIES;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   deht_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   deht_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   device_encounter_hysteresis_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Shadow copy of the table and its registers.
   logic [31:0] dwell_reg, disc_to_reg, enc_to_reg;
   logic [7:0] needed_reg;
   logic signed [7:0] thresh_reg;
   logic tbl_valid [NSLOT];
   logic tbl_enc [NSLOT];
   logic [31:0] tbl_id [NSLOT];
   logic [7:0] tbl_count [NSLOT];
   logic [31:0] tbl_first [NSLOT];
   logic [31:0] tbl_last [NSLOT];

   deht_pkg::rsp_type expected_rsp[$];
   int errors = 0;
   int cycles = 0;
   int sent = 0;
   int removals = 0;
   int send_idle = 0;
   int recv_idle = 0;
   // Pool of ids so that lookups hit existing entries most of the time.
   logic [31:0] id_pool [24];
   logic [31:0] clock_ms = 32'd1000;

   function automatic deht_pkg::rsp_type make_rsp(logic kind, logic [31:0] id, logic hs,
                                                  logic nd, logic full, logic [31:0] t,
                                                  logic lst);
      deht_pkg::rsp_type r;
      r.kind = kind; r.out_device_id = id; r.handshake = hs;
      r.newly_discovered = nd; r.table_full = full; r.event_time_ms = t; r.last = lst;
      return r;
   endfunction

   // Append one answer to the end of the prediction queue.
   task automatic queue_rsp(input deht_pkg::rsp_type r);
      expected_rsp = {expected_rsp, r};
   endtask

   // Apply one request to the shadow table and queue the answers it produces.
   task automatic predict_table(input deht_pkg::req_type rq);
      int hit, freep;
      logic hs, nd;
      deht_pkg::rsp_type pend;
      logic have_pend;
      hit = -1; freep = -1; have_pend = 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
         if (tbl_valid[i] && tbl_id[i] == rq.device_id && hit < 0) hit = i;
         if (!tbl_valid[i] && freep < 0) freep = i;
      end
      case (rq.op)
         deht_pkg::OP_DISCOVER: begin
            nd = 1'b0; hs = 1'b0;
            if (hit < 0 && freep < 0) begin
               queue_rsp(make_rsp(deht_pkg::KIND_DISCOVER, rq.device_id, 1'b0, 1'b0, 1'b1,
                                  32'd0, 1'b1));
               return;
            end
            if (hit < 0) begin
               hit = freep; nd = 1'b1;
               tbl_valid[hit] = 1'b1; tbl_enc[hit] = 1'b0; tbl_id[hit] = rq.device_id;
               tbl_count[hit] = 8'd0; tbl_first[hit] = rq.now_ms;
            end
            tbl_last[hit] = rq.now_ms;
            if (rq.strength > thresh_reg && tbl_count[hit] != 8'hFF)
               tbl_count[hit]++;
            if (tbl_enc[hit]) hs = 1'b1;
            else if (tbl_count[hit] >= needed_reg &&
                     32'(tbl_last[hit] - tbl_first[hit]) >= dwell_reg) begin
               tbl_enc[hit] = 1'b1; hs = 1'b1;
            end
            queue_rsp(make_rsp(deht_pkg::KIND_DISCOVER, rq.device_id, hs, nd, 1'b0,
                               nd ? rq.now_ms : 32'd0, 1'b1));
         end
         deht_pkg::OP_CONFIRM: begin
            if (hit >= 0) tbl_enc[hit] = 1'b1;
            else if (freep >= 0) begin
               tbl_valid[freep] = 1'b1; tbl_enc[freep] = 1'b1; tbl_id[freep] = rq.device_id;
               tbl_count[freep] = 8'd0; tbl_first[freep] = rq.now_ms;
               tbl_last[freep] = rq.now_ms;
            end
         end
         deht_pkg::OP_SWEEP: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (tbl_valid[i] && 32'(rq.now_ms - tbl_last[i]) >
                   (tbl_enc[i] ? enc_to_reg : disc_to_reg)) begin
                  tbl_valid[i] = 1'b0;
                  if (have_pend) queue_rsp(pend);
                  pend = make_rsp(deht_pkg::KIND_REMOVED, tbl_id[i], 1'b0, 1'b0, 1'b0,
                                  tbl_last[i], 1'b0);
                  have_pend = 1'b1;
                  removals++;
               end
            end
            if (have_pend) begin
               pend.last = 1'b1;
               queue_rsp(pend);
            end
         end
         default: ;
      endcase
   endtask

   // Send one request, with random idle ahead of it, and predict its answers.
   // Valid stays high after acceptance until the next request or an idle gap.
   task automatic send_req(input logic [1:0] op, input logic [31:0] id,
                           input logic signed [7:0] strength, input logic [31:0] now);
      deht_pkg::req_type rq;
      rq.op = op; rq.device_id = id; rq.strength = strength; rq.now_ms = now;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_table(rq);
      sent++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      csr_write <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      case (idx)
         deht_pkg::CSR_MIN_DWELL: dwell_reg = val;
         deht_pkg::CSR_DISC_TIMEOUT: disc_to_reg = val;
         deht_pkg::CSR_SIGHTINGS: needed_reg = val[7:0];
         deht_pkg::CSR_ENC_TIMEOUT: enc_to_reg = val;
         deht_pkg::CSR_THRESHOLD: thresh_reg = val[7:0];
         default: ;
      endcase
   endtask

   // Drop valid, drain outstanding answers, then hold off for a trailing confirm.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (3 * NSLOT + 10) @(posedge clock);
   endtask

   task automatic set_policy(input logic [31:0] dwell, input logic [31:0] dto,
                             input logic [7:0] need, input logic [31:0] eto,
                             input logic signed [7:0] thr);
      wait_idle();
      write_csr(deht_pkg::CSR_MIN_DWELL, dwell);
      write_csr(deht_pkg::CSR_DISC_TIMEOUT, dto);
      write_csr(deht_pkg::CSR_SIGHTINGS, {24'd0, need});
      write_csr(deht_pkg::CSR_ENC_TIMEOUT, eto);
      write_csr(deht_pkg::CSR_THRESHOLD, {{24{thr[7]}}, thr});
      csr_write <= 1'b0;
   endtask

   // Receiver: stall at random, check each answer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected answer, expected none, actual %p", $time, rsp_data);
            errors++;
         end else begin
            deht_pkg::rsp_type exp_r;
            exp_r = expected_rsp.pop_front();
            if (rsp_data !== exp_r) begin
               $display("%0t: answer mismatch, expected %p, actual %p", $time, exp_r, rsp_data);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Extremes of every field, every op, full table, unused op.
   task automatic test_directed();
      set_policy(32'd0, 32'd0, 8'd0, 32'd0, 8'sd0);
      send_req(deht_pkg::OP_DISCOVER, 32'hFFFF_FFFF, 8'sd127, 32'hFFFF_FFFF); // promotes
      send_req(deht_pkg::OP_DISCOVER, 32'h0, -8'sd128, 32'h0);
      send_req(OP_UNUSED, 32'h0, 8'sd0, 32'h0);                                // ignored
      send_req(deht_pkg::OP_SWEEP, 32'h1234, 8'sd5, 32'h0000_0001);           // wrapping idle
      set_policy(32'd100, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, -8'sd128);
      for (int i = 0; i < 16; i++)
         send_req(deht_pkg::OP_DISCOVER, 32'hA000 + i, 8'sd0, 32'd10);
      send_req(deht_pkg::OP_DISCOVER, 32'hBEEF, 8'sd0, 32'd11);               // table full
      send_req(deht_pkg::OP_CONFIRM, 32'hBEEF, 8'sd0, 32'd11);                // dropped
      send_req(deht_pkg::OP_CONFIRM, 32'hA003, 8'sd0, 32'd12);
      send_req(deht_pkg::OP_DISCOVER, 32'hA003, 8'sd0, 32'd13);               // handshake
      set_policy(32'd0, 32'd0, 8'd1, 32'd5, 8'sd127);
      send_req(deht_pkg::OP_SWEEP, 32'd0, 8'sd0, 32'd14);                     // many removals
      send_req(deht_pkg::OP_SWEEP, 32'd0, 8'sd0, 32'd40);
   endtask

   // Empty the table, then saturate one entry's count at its limit.
   task automatic test_saturation();
      set_policy(32'd0, 32'd0, 8'd0, 32'd0, 8'sd0);
      send_req(deht_pkg::OP_SWEEP, 32'd0, 8'sd0, clock_ms + 32'd1);
      send_req(deht_pkg::OP_SWEEP, 32'd0, 8'sd0, clock_ms + 32'd2);
      set_policy(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, -8'sd128);
      for (int i = 0; i < 260; i++) send_req(deht_pkg::OP_DISCOVER, 32'h5A5A, 8'sd1, 32'd50);
      set_policy(32'd0, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, -8'sd128);
      send_req(deht_pkg::OP_DISCOVER, 32'h5A5A, 8'sd1, 32'd60);               // promotes at 255
      set_policy(32'd0, 32'd0, 8'd0, 32'd0, 8'sd0);
      send_req(deht_pkg::OP_SWEEP, 32'd0, 8'sd0, 32'd100);
   endtask

   // Random sightings from a small pool, with confirms, sweeps and noise.
   task automatic test_random(input int count);
      int pick;
      logic [1:0] op;
      logic [31:0] id;
      for (int i = 0; i < 24; i++) id_pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         op = pick < 70 ? deht_pkg::OP_DISCOVER : pick < 82 ? deht_pkg::OP_CONFIRM :
              pick < 97 ? deht_pkg::OP_SWEEP : OP_UNUSED;
         id = ($urandom_range(9) == 0) ? 32'($urandom) : id_pool[$urandom_range(23)];
         clock_ms += ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(40));
         send_req(op, id, 8'($urandom), clock_ms);
      end
   endtask

   task automatic test_random_phase(input int count);
      set_policy(32'($urandom_range(60)), 32'($urandom_range(200, 40)),
                 8'($urandom_range(4)), 32'($urandom_range(400, 100)),
                 8'($urandom_range(255)));
      test_random(count);
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
      dwell_reg = '0; disc_to_reg = '0; enc_to_reg = '0; needed_reg = '0; thresh_reg = '0;
      send_idle = 21; recv_idle = 62;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(40);
      send_idle = 62; recv_idle = 21;
      test_saturation();
      test_random_phase(35);
      test_random_phase(30);
      send_idle = 0; recv_idle = 0;
      test_random_phase(35);
      test_random_phase(30);
      wait_idle();
      $display("tb_top: %0d requests sent, %0d table removals reported", sent, removals);
      $display("tb_top: covered full table, count saturation, wrapping time, all five registers");
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
src/deht_pkg.sv
src/deht_ram.sv
src/device_encounter_hysteresis_table.sv
dv/tb_top.sv
